>>> rtl/core/http_request_head_tokenizer_unit_defines.svh
// Assertion helpers shared by the RTL of the request head tokenizer.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef HTTP_REQUEST_HEAD_TOKENIZER_UNIT_DEFINES_SVH
`define HTTP_REQUEST_HEAD_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define HRHT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer check failed");

// Next-cycle implication.
`define HRHT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer check failed");

`endif

>>> rtl/core/hrht_pkg.sv
package hrht_pkg;

	localparam int FIELD_LEN_MAX_DEF = 8192;
	localparam int HEADERS_MAX_DEF   = 64;

	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic [12:0] OFFSET_SAT = 13'h1FFF;
	localparam logic [1:0]  LINE_SHORT = 2'd2;

	localparam logic [2:0] CL_METHOD  = 3'd0;
	localparam logic [2:0] CL_PATH    = 3'd1;
	localparam logic [2:0] CL_VERSION = 3'd2;
	localparam logic [2:0] CL_NAME    = 3'd3;
	localparam logic [2:0] CL_VALUE   = 3'd4;
	localparam logic [2:0] CL_DELIM   = 3'd5;
	localparam logic [2:0] CL_IGN     = 3'd6;

	localparam logic [1:0] ST_PROGRESS = 2'd0;
	localparam logic [1:0] ST_ACCEPT   = 2'd1;
	localparam logic [1:0] ST_ERROR    = 2'd2;

	localparam logic [2:0] ERR_NONE  = 3'd0;
	localparam logic [2:0] ERR_EMPTY = 3'd1;
	localparam logic [2:0] ERR_LONG  = 3'd2;
	localparam logic [2:0] ERR_SEP   = 3'd3;
	localparam logic [2:0] ERR_MANY  = 3'd4;
	localparam logic [2:0] ERR_TRUNC = 3'd5;

	localparam logic [2:0] REG_METHOD_LIMIT  = 3'd0;
	localparam logic [2:0] REG_PATH_LIMIT    = 3'd1;
	localparam logic [2:0] REG_VERSION_LIMIT = 3'd2;
	localparam logic [2:0] REG_NAME_LIMIT    = 3'd3;
	localparam logic [2:0] REG_VALUE_LIMIT   = 3'd4;
	localparam logic [2:0] REG_HEADER_LIMIT  = 3'd5;

	typedef enum logic [6:0] {
		PH_METHOD     = 7'b0000001,
		PH_PATH       = 7'b0000010,
		PH_VERSION    = 7'b0000100,
		PH_NAME       = 7'b0001000,
		PH_VALUE_LEAD = 7'b0010000,
		PH_VALUE      = 7'b0100000,
		PH_DONE       = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [13:0] method_limit;
		logic [13:0] path_limit;
		logic [13:0] version_limit;
		logic [13:0] name_limit;
		logic [13:0] value_limit;
		logic [6:0]  header_limit;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  deferred;
		logic [1:0]  status;
		logic [2:0]  error;
	} ctl_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic [2:0]  field_class;
		logic [5:0]  header_index;
		logic [12:0] field_offset;
		logic [1:0]  status;
		logic [2:0]  error_cause;
		logic [6:0]  lines_done;
	} res_t;

endpackage

>>> rtl/core/hrht_cfg.sv
module hrht_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [13:0]         cfg_data,
	output hrht_pkg::cfg_t      cfg
);

	hrht_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.method_limit  <= 14'd16;
			cfg_q.path_limit    <= 14'd2048;
			cfg_q.version_limit <= 14'd16;
			cfg_q.name_limit    <= 14'd256;
			cfg_q.value_limit   <= 14'd4096;
			cfg_q.header_limit  <= 7'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hrht_pkg::REG_METHOD_LIMIT:  cfg_q.method_limit  <= cfg_data;
				hrht_pkg::REG_PATH_LIMIT:    cfg_q.path_limit    <= cfg_data;
				hrht_pkg::REG_VERSION_LIMIT: cfg_q.version_limit <= cfg_data;
				hrht_pkg::REG_NAME_LIMIT:    cfg_q.name_limit    <= cfg_data;
				hrht_pkg::REG_VALUE_LIMIT:   cfg_q.value_limit   <= cfg_data;
				hrht_pkg::REG_HEADER_LIMIT:  cfg_q.header_limit  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/hrht_parser.sv
module hrht_parser #(
	parameter int FIELD_LEN_MAX = hrht_pkg::FIELD_LEN_MAX_DEF,
	parameter int HEADERS_MAX   = hrht_pkg::HEADERS_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                is_last,
	input  hrht_pkg::cfg_t      cfg,
	output hrht_pkg::res_t      res
);

	localparam int FL_W = $clog2(FIELD_LEN_MAX + 1);
	localparam int HC_W = $clog2(HEADERS_MAX + 1);
	localparam int EW   = (FL_W + 1 > 14) ? FL_W + 1 : 14;
	localparam int HL_W = (HC_W > 7) ? HC_W : 7;
	localparam int OW   = (FL_W > 13) ? FL_W : 13;

	hrht_pkg::ctl_t ctl_q;
	logic [FL_W-1:0] fl_q;
	logic [HC_W-1:0] hd_q;
	logic            cr_q;
	logic [1:0]      lb_q;

	hrht_pkg::ctl_t c;
	logic [FL_W-1:0] fl;
	logic [HC_W-1:0] hd;
	logic            cr;
	logic [1:0]      lb;
	logic [1:0]      was;
	logic [2:0]      cls;
	logic [FL_W-1:0] off;
	logic [HC_W-1:0] idx;
	logic [HL_W-1:0] hlim;
	logic [HL_W-1:0] idx_e;
	logic [HL_W-1:0] hd_e;
	logic [OW-1:0]   off_e;
	logic [EW-1:0]   eff_method;
	logic [EW-1:0]   eff_path;
	logic [EW-1:0]   eff_version;
	logic [EW-1:0]   eff_name;
	logic [EW-1:0]   eff_value;

	function automatic logic [EW-1:0] eff_f(logic [13:0] lim);
		logic [EW-1:0] l;
		l = EW'(lim);
		return (l > EW'(FIELD_LEN_MAX)) ? EW'(FIELD_LEN_MAX) : l;
	endfunction

	function automatic logic in_hdr(hrht_pkg::phase_t ph);
		return (ph == hrht_pkg::PH_NAME) || (ph == hrht_pkg::PH_VALUE_LEAD) ||
			(ph == hrht_pkg::PH_VALUE);
	endfunction

	// An error in the first two bytes of a header line is held until the third byte.
	function automatic hrht_pkg::ctl_t fail_f(hrht_pkg::ctl_t st, logic [1:0] line,
		logic [2:0] cause);
		hrht_pkg::ctl_t r;
		r = st;
		if (in_hdr(st.phase) && line <= hrht_pkg::LINE_SHORT) begin
			if (r.deferred == hrht_pkg::ERR_NONE) r.deferred = cause;
		end else begin
			r.status = hrht_pkg::ST_ERROR;
			r.error  = cause;
			r.phase  = hrht_pkg::PH_DONE;
		end
		return r;
	endfunction

	assign eff_method  = eff_f(cfg.method_limit);
	assign eff_path    = eff_f(cfg.path_limit);
	assign eff_version = eff_f(cfg.version_limit);
	assign eff_name    = eff_f(cfg.name_limit);
	assign eff_value   = eff_f(cfg.value_limit);
	assign hlim = (HL_W'(cfg.header_limit) > HL_W'(HEADERS_MAX)) ? HL_W'(HEADERS_MAX) :
		HL_W'(cfg.header_limit);

	always_comb begin
		c   = ctl_q;
		fl  = fl_q;
		hd  = hd_q;
		cr  = cr_q;
		lb  = lb_q;
		was = lb_q;
		cls = hrht_pkg::CL_IGN;
		off = '0;
		idx = '0;
		if (c.phase != hrht_pkg::PH_DONE) begin
			if (in_hdr(c.phase)) begin
				idx = hd;
				if (was != 2'd3) lb = was + 2'd1;
				if (was == hrht_pkg::LINE_SHORT) begin
					if (HL_W'(hd) >= hlim) c = fail_f(c, lb, hrht_pkg::ERR_MANY);
					else if (c.deferred != hrht_pkg::ERR_NONE) c = fail_f(c, lb, c.deferred);
				end
			end
			if (c.phase != hrht_pkg::PH_DONE && c.deferred == hrht_pkg::ERR_NONE) begin
				unique case (c.phase)
					hrht_pkg::PH_METHOD, hrht_pkg::PH_PATH: begin
						if (data_byte == hrht_pkg::CH_SP) begin
							if (fl == '0) c = fail_f(c, lb, hrht_pkg::ERR_EMPTY);
							else begin
								cls = hrht_pkg::CL_DELIM;
								c.phase = (c.phase == hrht_pkg::PH_METHOD) ?
									hrht_pkg::PH_PATH : hrht_pkg::PH_VERSION;
								fl = '0;
							end
						end else if (data_byte == hrht_pkg::CH_CR ||
							data_byte == hrht_pkg::CH_LF) begin
							c = fail_f(c, lb, hrht_pkg::ERR_SEP);
						end else begin
							off = fl;
							fl = fl + FL_W'(1);
							if (EW'(fl) >= ((c.phase == hrht_pkg::PH_METHOD) ? eff_method :
								eff_path)) begin
								c = fail_f(c, lb, hrht_pkg::ERR_LONG);
							end else begin
								cls = (c.phase == hrht_pkg::PH_METHOD) ? hrht_pkg::CL_METHOD :
									hrht_pkg::CL_PATH;
							end
						end
					end
					hrht_pkg::PH_VERSION: begin
						if (cr) begin
							if (data_byte == hrht_pkg::CH_LF) begin
								cls = hrht_pkg::CL_DELIM;
								cr = 1'b0;
								c.phase = hrht_pkg::PH_NAME;
								lb = '0;
								fl = '0;
							end else c = fail_f(c, lb, hrht_pkg::ERR_SEP);
						end else if (data_byte == hrht_pkg::CH_CR) begin
							if (fl == '0) c = fail_f(c, lb, hrht_pkg::ERR_EMPTY);
							else begin
								cr = 1'b1;
								cls = hrht_pkg::CL_DELIM;
							end
						end else if (data_byte == hrht_pkg::CH_LF) begin
							c = fail_f(c, lb, hrht_pkg::ERR_SEP);
						end else begin
							off = fl;
							fl = fl + FL_W'(1);
							if (EW'(fl) >= eff_version) c = fail_f(c, lb, hrht_pkg::ERR_LONG);
							else cls = hrht_pkg::CL_VERSION;
						end
					end
					hrht_pkg::PH_NAME: begin
						if (cr) begin
							if (data_byte == hrht_pkg::CH_LF) begin
								cls = hrht_pkg::CL_DELIM;
								c.status = hrht_pkg::ST_ACCEPT;
								c.phase = hrht_pkg::PH_DONE;
							end else c = fail_f(c, lb, hrht_pkg::ERR_SEP);
						end else if (data_byte == hrht_pkg::CH_CR) begin
							if (fl == '0) begin
								cr = 1'b1;
								cls = hrht_pkg::CL_DELIM;
							end else c = fail_f(c, lb, hrht_pkg::ERR_SEP);
						end else if (data_byte == hrht_pkg::CH_LF) begin
							c = fail_f(c, lb, hrht_pkg::ERR_SEP);
						end else if (data_byte == hrht_pkg::CH_COLON) begin
							if (fl == '0) c = fail_f(c, lb, hrht_pkg::ERR_EMPTY);
							else if (EW'(fl) >= eff_name) c = fail_f(c, lb, hrht_pkg::ERR_LONG);
							else begin
								cls = hrht_pkg::CL_DELIM;
								c.phase = hrht_pkg::PH_VALUE_LEAD;
								fl = '0;
							end
						end else begin
							off = fl;
							fl = fl + FL_W'(1);
							if (EW'(fl) >= eff_name) c = fail_f(c, lb, hrht_pkg::ERR_LONG);
							else cls = hrht_pkg::CL_NAME;
						end
					end
					hrht_pkg::PH_VALUE_LEAD, hrht_pkg::PH_VALUE: begin
						if (cr) begin
							if (data_byte == hrht_pkg::CH_LF) begin
								cls = hrht_pkg::CL_DELIM;
								cr = 1'b0;
								hd = hd + HC_W'(1);
								c.phase = hrht_pkg::PH_NAME;
								lb = '0;
								fl = '0;
							end else c = fail_f(c, lb, hrht_pkg::ERR_SEP);
						end else if (data_byte == hrht_pkg::CH_CR) begin
							if (EW'(fl) >= eff_value) c = fail_f(c, lb, hrht_pkg::ERR_LONG);
							else begin
								cr = 1'b1;
								cls = hrht_pkg::CL_DELIM;
							end
						end else if (data_byte == hrht_pkg::CH_LF) begin
							c = fail_f(c, lb, hrht_pkg::ERR_SEP);
						end else if (c.phase == hrht_pkg::PH_VALUE_LEAD &&
							data_byte == hrht_pkg::CH_SP) begin
							cls = hrht_pkg::CL_DELIM;
						end else begin
							c.phase = hrht_pkg::PH_VALUE;
							off = fl;
							fl = fl + FL_W'(1);
							if (EW'(fl) >= eff_value) c = fail_f(c, lb, hrht_pkg::ERR_LONG);
							else cls = hrht_pkg::CL_VALUE;
						end
					end
					default: ;
				endcase
			end
		end
		if (is_last && c.status == hrht_pkg::ST_PROGRESS) begin
			if (in_hdr(c.phase) && lb <= hrht_pkg::LINE_SHORT) c.status = hrht_pkg::ST_ACCEPT;
			else begin
				c.status = hrht_pkg::ST_ERROR;
				c.error  = hrht_pkg::ERR_TRUNC;
			end
		end
	end

	assign idx_e = HL_W'(idx);
	assign hd_e  = HL_W'(hd);
	assign off_e = OW'(off);

	always_comb begin
		res.byte_out     = data_byte;
		res.field_class  = cls;
		res.header_index = (cls == hrht_pkg::CL_IGN) ? 6'd0 : idx_e[5:0];
		if (cls == hrht_pkg::CL_IGN || cls == hrht_pkg::CL_DELIM) res.field_offset = '0;
		else if (off_e > OW'(hrht_pkg::OFFSET_SAT)) res.field_offset = hrht_pkg::OFFSET_SAT;
		else res.field_offset = off_e[12:0];
		res.status       = c.status;
		res.error_cause  = c.error;
		res.lines_done   = hd_e[6:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.phase    <= hrht_pkg::PH_METHOD;
			ctl_q.deferred <= hrht_pkg::ERR_NONE;
			ctl_q.status   <= hrht_pkg::ST_PROGRESS;
			ctl_q.error    <= hrht_pkg::ERR_NONE;
			fl_q <= '0;
			hd_q <= '0;
			cr_q <= 1'b0;
			lb_q <= '0;
		end else if (step) begin
			if (is_last) begin
				ctl_q.phase    <= hrht_pkg::PH_METHOD;
				ctl_q.deferred <= hrht_pkg::ERR_NONE;
				ctl_q.status   <= hrht_pkg::ST_PROGRESS;
				ctl_q.error    <= hrht_pkg::ERR_NONE;
				fl_q <= '0;
				hd_q <= '0;
				cr_q <= 1'b0;
				lb_q <= '0;
			end else begin
				ctl_q <= c;
				fl_q  <= fl;
				hd_q  <= hd;
				cr_q  <= cr;
				lb_q  <= lb;
			end
		end
	end

endmodule

>>> rtl/core/http_request_head_tokenizer_unit.sv
// Request head tokenizer: tags each byte of an HTTP/1.1 request head.
// The slave stream carries one request byte per beat, with tlast on the final
// byte of the buffer. The master stream returns one beat per input beat, in
// order, with the byte, its field class in tuser and its header line, field
// offset, running status, error cause and completed header count in tdata.
// Limits are set through the write port (cfg_we, cfg_index, cfg_data); the user
// must set them while no beat is in flight, which the block does not enforce.
// A limit register index past the last is ignored. A byte passes an input
// register and then a result register. The parse state is updated once per byte,
// which sustains one beat per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more byte; tready drops only when both are full.
// The beat that carries tlast shows the final status, after which the parse
// state returns to its reset value while the limit registers keep theirs.
// Reset clears both registers' valid flags and the parse state, and sets the limits to their defaults.
`include "http_request_head_tokenizer_unit_defines.svh"

module http_request_head_tokenizer_unit #(
	parameter int FIELD_LEN_MAX = hrht_pkg::FIELD_LEN_MAX_DEF,
	parameter int HEADERS_MAX   = hrht_pkg::HEADERS_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [13:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// byte_out, header_index, field_offset, status, error_cause, lines_done, zero pad
	output logic [39:0] m_axis_tdata,
	output logic [2:0]  m_axis_tuser   // field_class
);

	hrht_pkg::cfg_t cfg;
	hrht_pkg::res_t res;
	hrht_pkg::res_t res_s2;
	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           last_s1;
	logic           valid_s2;
	logic           advance;
	logic           take;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign take          = s_axis_tvalid && s_axis_tready;

	hrht_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hrht_parser #(
		.FIELD_LEN_MAX (FIELD_LEN_MAX),
		.HEADERS_MAX   (HEADERS_MAX)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.is_last   (last_s1),
		.cfg       (cfg),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_s2 <= res;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.field_class;
	assign m_axis_tdata  = {1'b0, res_s2.lines_done, res_s2.error_cause, res_s2.status,
		res_s2.field_offset, res_s2.header_index, res_s2.byte_out};

	`HRHT_ASSERT_NOW(a_stall_only_when_full, !s_axis_tready,
		valid_s1 && valid_s2 && !m_axis_tready)
	`HRHT_ASSERT_NOW(a_error_has_cause, valid_s2,
		(res_s2.status == hrht_pkg::ST_ERROR) == (res_s2.error_cause != hrht_pkg::ERR_NONE))
	`HRHT_ASSERT_NOW(a_offset_only_in_field, valid_s2 && res_s2.field_offset != 13'd0,
		res_s2.field_class != hrht_pkg::CL_DELIM && res_s2.field_class != hrht_pkg::CL_IGN)
	`HRHT_ASSERT_NEXT(a_result_moves_on, advance && !take, !valid_s1 && valid_s2)

endmodule
